### rtl/mdc_pkg.sv
// Shared types, constants and inverse tables for the modular diffusion cipher pass.
package mdc_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int LEVELS     = 1 << PIXEL_BITS;
    localparam int PRIME      = LEVELS + 1;
    localparam int ODD_COUNT  = LEVELS / 2;

    typedef logic [PIXEL_BITS-1:0] t_byte;

    // pass mode codes
    typedef enum logic [1:0] {
        MODE_ENC_FWD  = 2'd0,
        MODE_ENC_BWD  = 2'd1,
        MODE_UNDO_BWD = 2'd2,
        MODE_UNDO_FWD = 2'd3
    } t_pass_mode;

    // one input item
    typedef struct packed {
        t_byte pixel_in;
        t_byte key_mult;
        t_byte key_add;
        logic  first_item;
    } t_item;

    typedef logic [LEVELS-1:0][PIXEL_BITS-1:0]    t_tab_inv_prime;
    typedef logic [ODD_COUNT-1:0][PIXEL_BITS-1:0] t_tab_inv_odd;

    // inverse mod 257 by search, zero maps to zero
    function automatic t_tab_inv_prime f_build_inv_prime();
        t_tab_inv_prime tab;
        int a;
        int b;
        tab = '0;
        for (a = 1; a < LEVELS; a++) begin
            for (b = 1; b < LEVELS; b++) begin
                if (((a * b) % PRIME) == 1) begin
                    tab[a] = PIXEL_BITS'(b);
                end
            end
        end
        return tab;
    endfunction

    // inverse of odd values mod 256 by Newton steps; entry i serves 2*i+1
    function automatic t_tab_inv_odd f_build_inv_odd();
        t_tab_inv_odd tab;
        t_byte u;
        t_byte x;
        t_byte corr;
        logic [2*PIXEL_BITS-1:0] prod;
        int i;
        int k;
        tab = '0;
        for (i = 0; i < ODD_COUNT; i++) begin
            u = t_byte'(2 * i + 1);
            x = u;
            for (k = 0; k < 4; k++) begin
                prod = u * x;
                corr = t_byte'(2) - prod[PIXEL_BITS-1:0];
                prod = x * corr;
                x    = prod[PIXEL_BITS-1:0];
            end
            tab[i] = x;
        end
        return tab;
    endfunction

    localparam t_tab_inv_prime INV_PRIME = f_build_inv_prime();
    localparam t_tab_inv_odd   INV_ODD   = f_build_inv_odd();

endpackage

### rtl/mdc_kernel.sv
// Combinational diffusion step: key reduction, mode datapath and next chain byte.
module mdc_kernel (
    input  mdc_pkg::t_item      i_item,
    input  mdc_pkg::t_pass_mode i_mode,
    input  mdc_pkg::t_byte      i_chain,
    output mdc_pkg::t_byte      o_result,
    output mdc_pkg::t_byte      o_chain_next
);
    import mdc_pkg::*;

    t_byte                   key_m_red;
    t_byte                   key_a_red;
    t_byte                   u_odd;
    t_byte                   ch;
    t_byte                   p_xor;
    t_byte                   cur;
    t_byte                   inv_u;
    t_byte                   inv_p;
    logic [2*PIXEL_BITS-1:0] fwd_prod;
    logic [2*PIXEL_BITS-1:0] undo_prod;
    t_byte                   result;

    // reduce keys mod 255 (only all-ones wraps to zero)
    assign key_m_red = (i_item.key_mult == '1) ? '0 : i_item.key_mult;
    assign key_a_red = (i_item.key_add  == '1) ? '0 : i_item.key_add;

    // force the multiplier odd
    always_comb begin
        if (key_m_red == '0) begin
            u_odd = t_byte'(1);
        end else if (!key_m_red[0]) begin
            u_odd = key_m_red - t_byte'(1);
        end else begin
            u_odd = key_m_red;
        end
    end

    // first item of a pass skips the chaining xor
    assign ch    = i_item.first_item ? '0 : i_chain;
    assign p_xor = i_item.pixel_in ^ ch;

    // table lookups and the two multiplies
    assign inv_p     = INV_PRIME[i_item.pixel_in];
    assign inv_u     = INV_ODD[u_odd[PIXEL_BITS-1:1]];
    assign fwd_prod  = u_odd * inv_p;
    assign cur       = p_xor - key_a_red;
    assign undo_prod = inv_u * cur;

    // mode select and chain update
    always_comb begin
        unique case (i_mode)
            MODE_ENC_FWD: begin
                result       = (fwd_prod[PIXEL_BITS-1:0] + key_a_red) ^ ch;
                o_chain_next = result;
            end
            MODE_ENC_BWD: begin
                result       = ((i_item.pixel_in + u_odd) ^ key_a_red) ^ ch;
                o_chain_next = result;
            end
            MODE_UNDO_BWD: begin
                result       = (p_xor ^ key_a_red) - u_odd;
                o_chain_next = i_item.pixel_in;
            end
            MODE_UNDO_FWD: begin
                result       = INV_PRIME[undo_prod[PIXEL_BITS-1:0]];
                o_chain_next = i_item.pixel_in;
            end
            default: begin
                result       = '0;
                o_chain_next = i_chain;
            end
        endcase
    end

    assign o_result = result;

endmodule

### rtl/modular_diffusion_cipher_pass.sv
// Top level: input register, diffusion kernel, chain byte and result register.
// An item taken into the input register passes through the kernel to the result register, which drives o_pixel_out.
// Throughput: one item per clock while the output is not stalled; the chain byte loop closes through the kernel.
// Input stalls only while the input register is full and the waiting result is stalled.
// Synchronous active-low reset clears valids, pass mode (encrypt forward) and chain byte.
module modular_diffusion_cipher_pass (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [1:0]     i_cfg_wr_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mdc_pkg::t_byte i_pixel_in,
    input  mdc_pkg::t_byte i_key_mult,
    input  mdc_pkg::t_byte i_key_add,
    input  logic           i_first_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mdc_pkg::t_byte o_pixel_out
);
    import mdc_pkg::*;

    t_pass_mode r_pass_mode;
    logic       r_in_vld;
    t_item      r_item;
    t_byte      r_chain;
    logic       r_out_vld;
    t_byte      r_out_pixel;

    logic       out_free;
    logic       advance;
    logic       in_take;
    t_byte      n_result;
    t_byte      n_chain;

    // handshake control
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    mdc_kernel u_kernel (
        .i_item       (r_item),
        .i_mode       (r_pass_mode),
        .i_chain      (r_chain),
        .o_result     (n_result),
        .o_chain_next (n_chain)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_mode <= MODE_ENC_FWD;
        end else if (i_cfg_wr_en) begin
            r_pass_mode <= t_pass_mode'(i_cfg_wr_data);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.pixel_in   <= i_pixel_in;
            r_item.key_mult   <= i_key_mult;
            r_item.key_add    <= i_key_add;
            r_item.first_item <= i_first_item;
        end
    end

    // chain byte, updated as each item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (advance) begin
            r_chain <= n_chain;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pixel <= n_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_out = r_out_pixel;

endmodule

### sim/modular_diffusion_cipher_pass_test.sv
// Self-checking testbench for the modular diffusion cipher pass.
`timescale 1ns / 100ps

module modular_diffusion_cipher_pass_test;
    import mdc_pkg::*;

    localparam int BYTE_MASK   = LEVELS - 1;
    localparam int LONG_HOLD   = 400;   // cycles the receiver holds off once
    localparam int STALL_LIMIT = 5000;  // cycles with no item moved before giving up

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } t_rx_style;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    t_byte      pixel_in    = '0;
    t_byte      key_mult    = '0;
    t_byte      key_add     = '0;
    logic       first_item  = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    t_byte      pixel_out;

    // items waiting to be sent, and cipher bytes waiting to come out
    t_item      pending_items[$];
    t_byte      cipher_expect[$];

    // predictor state
    t_pass_mode mode_model  = MODE_ENC_FWD;
    t_byte      chain_model = '0;

    int         mismatch_count = 0;
    int         burst_left     = 0;
    int         gap_left       = 0;
    int         hold_req       = 0;
    int         hold_seen      = 0;
    int         hold_left      = 0;
    int         style_left     = 0;
    t_rx_style  rx_style       = RX_FREE;
    int         idle_cycles    = 0;

    modular_diffusion_cipher_pass uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pixel_in    (pixel_in),
        .i_key_mult    (key_mult),
        .i_key_add     (key_add),
        .i_first_item  (first_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_out   (pixel_out)
    );

    always #6 clk = ~clk;

    // inverse mod 257 by Fermat's little theorem; zero maps to zero
    function automatic int inv_mod_prime(input int a);
        int r;
        int b;
        int e;
        r = 1;
        b = a % PRIME;
        e = PRIME - 2;
        while (e != 0) begin
            if (e & 1) r = (r * b) % PRIME;
            b = (b * b) % PRIME;
            e = e >> 1;
        end
        return ((a % PRIME) == 0) ? 0 : r;
    endfunction

    // inverse of an odd byte mod 256 by search
    function automatic int inv_mod_byte(input int u);
        int x;
        for (x = 1; x < LEVELS; x += 2) begin
            if (((u * x) & BYTE_MASK) == 1) return x;
        end
        return 0;
    endfunction

    // one diffusion step; updates the chain byte
    function automatic t_byte diffuse_pixel(input t_byte p, input t_byte km,
                                            input t_byte ka, input logic first);
        int u;
        int v;
        int ch;
        int cur;
        int j;
        int y;
        u  = int'(km) % BYTE_MASK;
        v  = int'(ka) % BYTE_MASK;
        ch = first ? 0 : int'(chain_model);
        if (u == 0) u = 1;
        else if ((u % 2) == 0) u = u - 1;
        case (mode_model)
            MODE_ENC_FWD: begin
                y = ((u * inv_mod_prime(int'(p)) + v) & BYTE_MASK) ^ ch;
                chain_model = t_byte'(y);
            end
            MODE_ENC_BWD: begin
                y = ((int'(p) + u) & BYTE_MASK) ^ v ^ ch;
                chain_model = t_byte'(y);
            end
            MODE_UNDO_BWD: begin
                y = (((int'(p) ^ ch) ^ v) + LEVELS - u) & BYTE_MASK;
                chain_model = p;
            end
            default: begin
                cur = ((int'(p) ^ ch) + LEVELS - v) & BYTE_MASK;
                j   = (inv_mod_byte(u) * cur) & BYTE_MASK;
                y   = inv_mod_prime(j) & BYTE_MASK;
                chain_model = p;
            end
        endcase
        return t_byte'(y);
    endfunction

    // random byte with extra weight on the extremes
    function automatic t_byte pick_byte();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return t_byte'($urandom_range(0, BYTE_MASK));
    endfunction

    task automatic queue_item(input t_byte p, input t_byte km, input t_byte ka,
                              input logic first);
        t_item it;
        it.pixel_in   = p;
        it.key_mult   = km;
        it.key_add    = ka;
        it.first_item = first;
        pending_items = {pending_items, it};
    endtask

    // wait until every item is sent and every cipher byte has come out
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || cipher_expect.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_mode(input t_pass_mode m);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_model = m;
        @(negedge clk);
    endtask

    // driver: predicts accepted items, sends queued items in bursts
    always @(posedge clk) begin : item_driver
        t_item next_item;
        t_byte predicted;
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                predicted     = diffuse_pixel(pixel_in, key_mult, key_add, first_item);
                cipher_expect = {cipher_expect, predicted};
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    pixel_in   <= next_item.pixel_in;
                    key_mult   <= next_item.key_mult;
                    key_add    <= next_item.key_add;
                    first_item <= next_item.first_item;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: changing random pattern, plus one long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            style_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                rx_style   <= t_rx_style'($urandom_range(0, 3));
                style_left <= $urandom_range(16, 200);
            end else begin
                style_left <= style_left - 1;
            end
            case (rx_style)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
                default:  out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // monitor: compare each cipher byte with the oldest prediction
    always @(posedge clk) begin : cipher_monitor
        t_byte want;
        if (rst_n && out_valid && !out_stall) begin
            if (cipher_expect.size() == 0) begin
                mismatch_count++;
                $display("%0t: pixel_out %0d with no item outstanding", $time, pixel_out);
            end else begin
                want = cipher_expect.pop_front();
                if (pixel_out !== want) begin
                    mismatch_count++;
                    $display("%0t: pixel_out expected %0d, got %0d", $time, want, pixel_out);
                end
            end
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("modular_diffusion_cipher_pass: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int         mi;
        int         ph;
        int         left;
        int         len;
        int         k;
        logic       f;
        logic       pass_start;
        t_pass_mode m;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: key extremes, even and zero multipliers, zero pixel, first flag
        for (mi = 0; mi < 4; mi++) begin
            write_mode(t_pass_mode'(mi));
            queue_item(8'd0,   8'd0,   8'd0,   1'b1);
            queue_item(8'd255, 8'd255, 8'd255, 1'b0);
            queue_item(8'd1,   8'd254, 8'd1,   1'b0);
            queue_item(8'd128, 8'd2,   8'd254, 1'b0);
            queue_item(8'd254, 8'd1,   8'd128, 1'b1);
            queue_item(pick_byte(), 8'd127, 8'd0, 1'b0);
            wait_drained();
        end

        // random passes; a phase may continue the chain left by the last mode
        for (ph = 0; ph < 14; ph++) begin
            if (ph == 0) m = MODE_UNDO_FWD;
            else if (ph == 1) m = MODE_ENC_FWD;
            else m = t_pass_mode'($urandom_range(0, 3));
            write_mode(m);
            left = 110;
            pass_start = ($urandom_range(0, 3) != 0);
            while (left != 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 24);
                for (k = 0; k < len && left != 0; k++) begin
                    // stray first flags inside a pass as noise
                    f = (k == 0) ? pass_start : ($urandom_range(0, 19) == 0);
                    queue_item(pick_byte(), pick_byte(), pick_byte(), f);
                    left--;
                    // sender pauses mid-pass until the block has drained
                    if (ph == 4 && left == 55) wait_drained();
                end
                pass_start = 1'b1;
            end
            // long receiver hold while the whole phase is offered
            if (ph == 2) hold_req++;
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("modular_diffusion_cipher_pass: match");
        end else begin
            $display("modular_diffusion_cipher_pass: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mdc_pkg.sv
rtl/mdc_kernel.sv
rtl/modular_diffusion_cipher_pass.sv
sim/modular_diffusion_cipher_pass_test.sv
